### rtl/x86e_pkg.sv
// Package with opcodes, operation codes and shared types of the x86-64 encoder.
package x86e_pkg;

    localparam int MaxBytes  = 12;
    localparam int CntW      = 4;
    localparam int QueueDepth = 4;

    typedef enum logic [4:0] {
        F_MOV_RR = 5'd0, F_MOV_RI32 = 5'd1, F_MOV_RI64 = 5'd2, F_ADD_RR = 5'd3,
        F_SUB_RR = 5'd4, F_ADD_RI = 5'd5, F_IMUL_RR = 5'd6, F_AND_RR = 5'd7,
        F_OR_RR = 5'd8, F_XOR_RR = 5'd9, F_SHL_CL = 5'd10, F_SHR_CL = 5'd11,
        F_NOT_R = 5'd12, F_NEG_R = 5'd13, F_CMP_RR = 5'd14, F_TEST_RR = 5'd15,
        F_PUSH_R = 5'd16, F_POP_R = 5'd17, F_RET = 5'd18, F_CALL_R = 5'd19,
        F_JMP_REL = 5'd20, F_JMP_R = 5'd21, F_JCC_REL = 5'd22, F_SETCC_R = 5'd23,
        F_LOAD64 = 5'd24, F_STORE64 = 5'd25, F_LOAD64_IDX = 5'd26,
        F_STORE64_IDX = 5'd27, F_MOVABS_R = 5'd28, F_STORE_IMM32 = 5'd29,
        F_BAD30 = 5'd30, F_BAD31 = 5'd31
    } t_func;

    localparam logic [7:0] OpNotNeg = 8'hF7;
    localparam logic [7:0] OpAddI8  = 8'h83;
    localparam logic [7:0] OpAddI32 = 8'h81;
    localparam logic [7:0] OpMovI   = 8'hC7;
    localparam logic [7:0] OpMovR   = 8'hB8;
    localparam logic [7:0] OpJmp    = 8'hE9;
    localparam logic [7:0] OpEsc    = 8'h0F;
    localparam logic [7:0] OpImul   = 8'hAF;
    localparam logic [7:0] OpShift  = 8'hD3;
    localparam logic [7:0] OpRet    = 8'hC3;
    localparam logic [7:0] OpGrp5   = 8'hFF;
    localparam logic [7:0] OpStore  = 8'h89;
    localparam logic [7:0] OpLoad   = 8'h8B;
    localparam logic [7:0] OpAdd    = 8'h01;
    localparam logic [7:0] OpSub    = 8'h29;
    localparam logic [7:0] OpAnd    = 8'h21;
    localparam logic [7:0] OpOr     = 8'h09;
    localparam logic [7:0] OpXor    = 8'h31;
    localparam logic [7:0] OpCmp    = 8'h39;
    localparam logic [7:0] OpTest   = 8'h85;
    localparam logic [7:0] OpPush   = 8'h50;
    localparam logic [7:0] OpPop    = 8'h58;
    localparam logic [7:0] RexB     = 8'h41;
    localparam logic [7:0] RexBare  = 8'h40;
    localparam logic [7:0] SibRsp   = 8'h24;

    // Fully classified instruction: byte string plus its length.
    typedef struct packed {
        logic [MaxBytes*8-1:0] bytes;
        logic [CntW-1:0]       len;
    } t_enc;

endpackage

### rtl/x86_64_instruction_encoder.sv
// Top level of the x86-64 instruction encoder.
//  channel  | direction | handshake          | payload
//  request  | in        | i_push / o_full    | func, regs, scale, disp, imm, cond_byte
//  bytes    | out       | o_empty / i_pop    | out_byte, last
// One request is accepted per cycle while the queue has room; bytes leave one per
// cycle while i_pop is high, with a refill gap between instructions set by the
// registered read of the queue RAM.
// The first byte passes the front register, the queue RAM and the r_cur register.
// Synchronous active-low reset empties the queue. Each side stalls on its own.
module x86_64_instruction_encoder #(
    parameter int QDepth = x86e_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [4:0]         i_func,
    input  logic [3:0]         i_reg_a,
    input  logic [3:0]         i_reg_b,
    input  logic [3:0]         i_base_reg,
    input  logic [3:0]         i_index_reg,
    input  logic [1:0]         i_scale_log2,
    input  logic signed [31:0] i_disp,
    input  logic [63:0]        i_imm,
    input  logic [7:0]         i_cond_byte,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);
    import x86e_pkg::*;

    logic f_ready, f_valid, b_ready;
    t_enc enc;

    assign o_full = !f_ready;

    x86e_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_push), .o_ready(f_ready),
        .i_func(i_func), .i_reg_a(i_reg_a), .i_reg_b(i_reg_b),
        .i_base_reg(i_base_reg), .i_index_reg(i_index_reg),
        .i_scale_log2(i_scale_log2), .i_disp(i_disp), .i_imm(i_imm),
        .i_cond_byte(i_cond_byte),
        .o_valid(f_valid), .i_ready(b_ready), .o_enc(enc)
    );

    x86e_back #(.Depth(QDepth)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(b_ready), .i_enc(enc),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_out_byte(o_out_byte), .o_last(o_last)
    );
endmodule

### rtl/x86e_ram.sv
// Generic single-write, registered-read RAM.
module x86e_ram #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/x86e_front.sv
// Front end: accepts requests, registers them and builds the byte string.
module x86e_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [4:0]            i_func,
    input  logic [3:0]            i_reg_a,
    input  logic [3:0]            i_reg_b,
    input  logic [3:0]            i_base_reg,
    input  logic [3:0]            i_index_reg,
    input  logic [1:0]            i_scale_log2,
    input  logic signed [31:0]    i_disp,
    input  logic [63:0]           i_imm,
    input  logic [7:0]            i_cond_byte,
    output logic                  o_valid,
    input  logic                  i_ready,
    output x86e_pkg::t_enc        o_enc
);
    import x86e_pkg::*;

    logic        r_vld;
    logic [4:0]  r_func;
    logic [3:0]  r_ra, r_rb, r_base, r_idx;
    logic [1:0]  r_sc;
    logic [31:0] r_disp;
    logic [63:0] r_imm;
    logic [7:0]  r_cond;

    assign o_ready = !r_vld || (i_ready);
    assign o_valid = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_func <= i_func;
            r_ra   <= i_reg_a;
            r_rb   <= i_reg_b;
            r_base <= i_base_reg;
            r_idx  <= i_index_reg;
            r_sc   <= i_scale_log2;
            r_disp <= i_disp;
            r_imm  <= i_imm;
            r_cond <= i_cond_byte;
        end
    end

    function automatic logic [7:0] f_rex(input logic w, input logic [3:0] rg,
                                         input logic [3:0] ix, input logic [3:0] rm);
        return {4'h4, w, rg[3], ix[3], rm[3]};
    endfunction

    function automatic logic [7:0] f_modrm(input logic [1:0] md, input logic [2:0] rg,
                                           input logic [2:0] rm);
        return {md, rg, rm};
    endfunction

    logic [MaxBytes*8-1:0] bytes;
    logic [CntW-1:0]       len;

    // Appends one byte at the current length.
    function automatic void f_put(inout logic [MaxBytes*8-1:0] b, inout logic [CntW-1:0] n,
                                  input logic [7:0] v);
        b[n*8 +: 8] = v;
        n = n + CntW'(1);
    endfunction

    always_comb begin
        logic [7:0]  rx;
        logic        dz, d8, fp;
        logic [1:0]  md;
        logic [3:0]  mreg;
        logic [32:0] top;
        bytes = '0;
        len   = '0;
        rx    = 8'h00;
        mreg  = 4'd0;
        top   = r_imm[63:31];
        dz    = (r_disp == 32'd0);
        d8    = (r_disp[31:7] == '0) || (r_disp[31:7] == '1);
        fp    = (r_base[2:0] == 3'd5);
        md    = (dz && !fp) ? 2'd0 : (d8 ? 2'd1 : 2'd2);
        unique case (t_func'(r_func))
            F_MOV_RR, F_ADD_RR, F_SUB_RR, F_AND_RR, F_OR_RR, F_XOR_RR,
            F_CMP_RR, F_TEST_RR: begin
                if (!(r_func == F_MOV_RR && r_ra == r_rb)) begin
                    f_put(bytes, len, f_rex(1'b1, r_rb, 4'd0, r_ra));
                    unique case (t_func'(r_func))
                        F_MOV_RR: f_put(bytes, len, OpStore);
                        F_ADD_RR: f_put(bytes, len, OpAdd);
                        F_SUB_RR: f_put(bytes, len, OpSub);
                        F_AND_RR: f_put(bytes, len, OpAnd);
                        F_OR_RR:  f_put(bytes, len, OpOr);
                        F_XOR_RR: f_put(bytes, len, OpXor);
                        F_CMP_RR: f_put(bytes, len, OpCmp);
                        default:  f_put(bytes, len, OpTest);
                    endcase
                    f_put(bytes, len, f_modrm(2'd3, r_rb[2:0], r_ra[2:0]));
                end
            end
            F_MOV_RI32, F_MOV_RI64: begin
                if (r_func == F_MOV_RI32 || top == '0) begin
                    if (r_ra[3]) f_put(bytes, len, RexB);
                    f_put(bytes, len, OpMovR | {5'd0, r_ra[2:0]});
                    for (int i = 0; i < 4; i++) f_put(bytes, len, r_imm[i*8 +: 8]);
                end else if (top == '1) begin
                    f_put(bytes, len, f_rex(1'b1, 4'd0, 4'd0, r_ra));
                    f_put(bytes, len, OpMovI);
                    f_put(bytes, len, f_modrm(2'd3, 3'd0, r_ra[2:0]));
                    for (int i = 0; i < 4; i++) f_put(bytes, len, r_imm[i*8 +: 8]);
                end else begin
                    f_put(bytes, len, f_rex(1'b1, 4'd0, 4'd0, r_ra));
                    f_put(bytes, len, OpMovR | {5'd0, r_ra[2:0]});
                    for (int i = 0; i < 8; i++) f_put(bytes, len, r_imm[i*8 +: 8]);
                end
            end
            F_MOVABS_R: begin
                f_put(bytes, len, f_rex(1'b1, 4'd0, 4'd0, r_ra));
                f_put(bytes, len, OpMovR | {5'd0, r_ra[2:0]});
                for (int i = 0; i < 8; i++) f_put(bytes, len, r_imm[i*8 +: 8]);
            end
            F_ADD_RI: begin
                f_put(bytes, len, f_rex(1'b1, 4'd0, 4'd0, r_ra));
                if (r_imm[31:7] == '0 || r_imm[31:7] == '1) begin
                    f_put(bytes, len, OpAddI8);
                    f_put(bytes, len, f_modrm(2'd3, 3'd0, r_ra[2:0]));
                    f_put(bytes, len, r_imm[7:0]);
                end else begin
                    f_put(bytes, len, OpAddI32);
                    f_put(bytes, len, f_modrm(2'd3, 3'd0, r_ra[2:0]));
                    for (int i = 0; i < 4; i++) f_put(bytes, len, r_imm[i*8 +: 8]);
                end
            end
            F_IMUL_RR: begin
                f_put(bytes, len, f_rex(1'b1, r_ra, 4'd0, r_rb));
                f_put(bytes, len, OpEsc);
                f_put(bytes, len, OpImul);
                f_put(bytes, len, f_modrm(2'd3, r_ra[2:0], r_rb[2:0]));
            end
            F_SHL_CL, F_SHR_CL, F_NOT_R, F_NEG_R: begin
                f_put(bytes, len, f_rex(1'b1, 4'd0, 4'd0, r_ra));
                unique case (t_func'(r_func))
                    F_SHL_CL: begin
                        f_put(bytes, len, OpShift);
                        f_put(bytes, len, f_modrm(2'd3, 3'd4, r_ra[2:0]));
                    end
                    F_SHR_CL: begin
                        f_put(bytes, len, OpShift);
                        f_put(bytes, len, f_modrm(2'd3, 3'd5, r_ra[2:0]));
                    end
                    F_NOT_R: begin
                        f_put(bytes, len, OpNotNeg);
                        f_put(bytes, len, f_modrm(2'd3, 3'd2, r_ra[2:0]));
                    end
                    default: begin
                        f_put(bytes, len, OpNotNeg);
                        f_put(bytes, len, f_modrm(2'd3, 3'd3, r_ra[2:0]));
                    end
                endcase
            end
            F_PUSH_R, F_POP_R: begin
                if (r_ra[3]) f_put(bytes, len, RexB);
                f_put(bytes, len, ((r_func == F_PUSH_R) ? OpPush : OpPop)
                                  | {5'd0, r_ra[2:0]});
            end
            F_RET: f_put(bytes, len, OpRet);
            F_CALL_R, F_JMP_R: begin
                if (r_ra[3]) f_put(bytes, len, RexB);
                f_put(bytes, len, OpGrp5);
                f_put(bytes, len, f_modrm(2'd3, (r_func == F_CALL_R) ? 3'd2 : 3'd4,
                                          r_ra[2:0]));
            end
            F_JMP_REL: begin
                f_put(bytes, len, OpJmp);
                for (int i = 0; i < 4; i++) f_put(bytes, len, r_disp[i*8 +: 8]);
            end
            F_JCC_REL: begin
                f_put(bytes, len, OpEsc);
                f_put(bytes, len, r_cond);
                for (int i = 0; i < 4; i++) f_put(bytes, len, r_disp[i*8 +: 8]);
            end
            F_SETCC_R: begin
                // Registers 4 to 7 need a bare REX to select the low byte registers.
                if (r_ra[3]) f_put(bytes, len, RexB);
                else if (r_ra[2]) f_put(bytes, len, RexBare);
                f_put(bytes, len, OpEsc);
                f_put(bytes, len, r_cond);
                f_put(bytes, len, f_modrm(2'd3, 3'd0, r_ra[2:0]));
            end
            F_LOAD64, F_STORE64, F_STORE_IMM32: begin
                if (r_func == F_STORE_IMM32) begin
                    rx = f_rex(1'b0, 4'd0, 4'd0, r_base);
                    mreg = 4'd0;
                end else begin
                    rx = f_rex(1'b1, r_ra, 4'd0, r_base);
                    mreg = r_ra;
                end
                if (rx != RexBare) f_put(bytes, len, rx);
                f_put(bytes, len, (r_func == F_LOAD64) ? OpLoad :
                                  (r_func == F_STORE64) ? OpStore : OpMovI);
                f_put(bytes, len, f_modrm(md, mreg[2:0], r_base[2:0]));
                if (r_base[2:0] == 3'd4) f_put(bytes, len, SibRsp);
                if (md == 2'd1) f_put(bytes, len, r_disp[7:0]);
                else if (md == 2'd2) begin
                    for (int i = 0; i < 4; i++) f_put(bytes, len, r_disp[i*8 +: 8]);
                end
                if (r_func == F_STORE_IMM32) begin
                    for (int i = 0; i < 4; i++) f_put(bytes, len, r_imm[i*8 +: 8]);
                end
            end
            F_LOAD64_IDX, F_STORE64_IDX: begin
                f_put(bytes, len, f_rex(1'b1, r_ra, r_idx, r_base));
                f_put(bytes, len, (r_func == F_LOAD64_IDX) ? OpLoad : OpStore);
                f_put(bytes, len, f_modrm(fp ? 2'd1 : 2'd0, r_ra[2:0], 3'd4));
                f_put(bytes, len, {r_sc, r_idx[2:0], r_base[2:0]});
                if (fp) f_put(bytes, len, 8'h00);
            end
            default: ;
        endcase
    end

    assign o_enc = '{bytes: bytes, len: len};
endmodule

### rtl/x86e_back.sv
// Back end: queue of encoded instructions and byte serializer to the result port.
module x86e_back #(
    parameter int Depth = x86e_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  x86e_pkg::t_enc i_enc,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_out_byte,
    output logic           o_last
);
    import x86e_pkg::*;

    localparam int AW = $clog2(Depth);

    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    t_enc          r_cur;
    logic          r_cur_vld;
    logic [CntW-1:0] r_pos;
    logic          r_pend;      // a RAM read was issued last cycle
    t_enc          ram_q;
    logic          push, take, pop_ok, done, load;

    // Zero-length items never enter the queue.
    assign o_ready = (r_cnt != (AW+1)'(Depth));
    assign push    = i_valid && o_ready && (i_enc.len != '0);
    assign pop_ok  = i_pop && r_cur_vld;
    assign done    = pop_ok && (r_pos == r_cur.len - CntW'(1));
    assign take    = (r_cnt != '0) && !r_pend && (!r_cur_vld || done);

    x86e_ram #(.Width($bits(t_enc)), .Depth(Depth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (push),
        .i_waddr(r_wp),
        .i_wdata(i_enc),
        .i_raddr(r_rp),
        .o_rdata(ram_q)
    );

    assign load = r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
            r_cur_vld <= 1'b0; r_pos <= '0; r_pend <= 1'b0;
        end else begin
            if (push) r_wp <= r_wp + AW'(1);
            if (take) r_rp <= r_rp + AW'(1);
            r_cnt  <= r_cnt + (AW+1)'(push) - (AW+1)'(take);
            r_pend <= take;
            if (load) begin
                r_cur_vld <= 1'b1;
                r_pos     <= '0;
            end else if (done) begin
                r_cur_vld <= 1'b0;
            end else if (pop_ok) begin
                r_pos <= r_pos + CntW'(1);
            end
        end
        if (load) r_cur <= ram_q;
    end

    assign o_empty    = !r_cur_vld;
    assign o_out_byte = r_cur.bytes[r_pos*8 +: 8];
    assign o_last     = (r_pos == r_cur.len - CntW'(1));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(Depth)) else $error("queue count exceeds depth");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (!r_cur_vld || done)) else $error("read issued while busy");
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_vld |-> (r_cur.len != '0 && r_pos < r_cur.len))
        else $error("byte position out of range");
`endif
endmodule

### dv/tb_x86_64_instruction_encoder.sv
// Testbench for the x86-64 instruction encoder: directed and random requests checked byte by byte.
`timescale 1ns / 1ps

module tb_x86_64_instruction_encoder;
    import x86e_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [4:0]  i_func;
    logic [3:0]  i_reg_a;
    logic [3:0]  i_reg_b;
    logic [3:0]  i_base_reg;
    logic [3:0]  i_index_reg;
    logic [1:0]  i_scale_log2;
    logic signed [31:0] i_disp;
    logic [63:0] i_imm;
    logic [7:0]  i_cond_byte;
    logic        o_empty;
    logic        i_pop;
    logic [7:0]  o_out_byte;
    logic        o_last;

    typedef struct {
        t_func      func;
        logic [3:0] ra;
        logic [3:0] rb;
        logic [3:0] base;
        logic [3:0] idx;
        logic [1:0] sc;
        logic [31:0] disp;
        logic [63:0] imm;
        logic [7:0] cond;
    } t_req;

    // Each entry holds {byte, last}.
    logic [8:0] code_q[$];
    logic [7:0] enc_bytes[$];
    int error_count;
    int sent_count;
    int byte_count;
    int op_hits[32];
    bit quiet_stretch;

    x86_64_instruction_encoder i_dut (.*);

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic bit idle_now();
        return !quiet_stretch && ($urandom_range(99) < 34);
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void emit_rex(bit w, logic [3:0] r, logic [3:0] x, logic [3:0] b);
        logic [3:0] v;
        v = {w, r[3], x[3], b[3]};
        if (v != 4'd0) enc_bytes.push_back({4'h4, v});
    endfunction

    function automatic void emit_modrm(logic [1:0] md, logic [3:0] r, logic [3:0] rm);
        enc_bytes.push_back({md, r[2:0], rm[2:0]});
    endfunction

    function automatic void emit32(logic [31:0] v);
        for (int i = 0; i < 4; i++) enc_bytes.push_back(v[i*8 +: 8]);
    endfunction

    function automatic void emit_mem(logic [3:0] r, logic [3:0] base, logic [31:0] d);
        logic [1:0] md;
        if (d == 32'd0 && base[2:0] != 3'd5) md = 2'd0;
        else if ($signed(d) >= -128 && $signed(d) <= 127) md = 2'd1;
        else md = 2'd2;
        emit_modrm(md, r, base);
        if (base[2:0] == 3'd4) enc_bytes.push_back(SibRsp);
        if (md == 2'd1) enc_bytes.push_back(d[7:0]);
        else if (md == 2'd2) emit32(d);
    endfunction

    function automatic void emit_rr(logic [7:0] op, logic [3:0] r, logic [3:0] rm);
        emit_rex(1'b1, r, 4'd0, rm);
        enc_bytes.push_back(op);
        emit_modrm(2'd3, r, rm);
    endfunction

    function automatic void emit_ext(logic [7:0] op, logic [2:0] ext, logic [3:0] rm, bit w);
        if (w) emit_rex(1'b1, 4'd0, 4'd0, rm);
        else if (rm[3]) enc_bytes.push_back(RexB);
        enc_bytes.push_back(op);
        emit_modrm(2'd3, {1'b0, ext}, rm);
    endfunction

    function automatic void emit_idx(logic [7:0] op, t_req q);
        emit_rex(1'b1, q.ra, q.idx, q.base);
        enc_bytes.push_back(op);
        emit_modrm(q.base[2:0] == 3'd5 ? 2'd1 : 2'd0, q.ra, 4'd4);
        enc_bytes.push_back({q.sc, q.idx[2:0], q.base[2:0]});
        if (q.base[2:0] == 3'd5) enc_bytes.push_back(8'h00);
    endfunction

    function automatic void emit_short_mov(logic [3:0] r, logic [31:0] v);
        if (r[3]) enc_bytes.push_back(RexB);
        enc_bytes.push_back(OpMovR | {5'd0, r[2:0]});
        emit32(v);
    endfunction

    // Encodes one request into enc_bytes.
    function automatic void encode_instr(t_req q);
        logic [32:0] top;
        top = q.imm[63:31];
        enc_bytes.delete();
        case (q.func)
            F_MOV_RR:   if (q.ra != q.rb) emit_rr(OpStore, q.rb, q.ra);
            F_MOV_RI32: emit_short_mov(q.ra, q.imm[31:0]);
            F_MOV_RI64: begin
                if (top == 33'd0) emit_short_mov(q.ra, q.imm[31:0]);
                else if (&top) begin
                    emit_ext(OpMovI, 3'd0, q.ra, 1'b1);
                    emit32(q.imm[31:0]);
                end else begin
                    emit_rex(1'b1, 4'd0, 4'd0, q.ra);
                    enc_bytes.push_back(OpMovR | {5'd0, q.ra[2:0]});
                    emit32(q.imm[31:0]);
                    emit32(q.imm[63:32]);
                end
            end
            F_ADD_RR:   emit_rr(OpAdd, q.rb, q.ra);
            F_SUB_RR:   emit_rr(OpSub, q.rb, q.ra);
            F_ADD_RI: begin
                if (q.imm[31:0] >= 32'hFFFFFF80 || q.imm[31:0] <= 32'h7F) begin
                    emit_ext(OpAddI8, 3'd0, q.ra, 1'b1);
                    enc_bytes.push_back(q.imm[7:0]);
                end else begin
                    emit_ext(OpAddI32, 3'd0, q.ra, 1'b1);
                    emit32(q.imm[31:0]);
                end
            end
            F_IMUL_RR: begin
                emit_rex(1'b1, q.ra, 4'd0, q.rb);
                enc_bytes.push_back(OpEsc);
                enc_bytes.push_back(OpImul);
                emit_modrm(2'd3, q.ra, q.rb);
            end
            F_AND_RR:   emit_rr(OpAnd, q.rb, q.ra);
            F_OR_RR:    emit_rr(OpOr, q.rb, q.ra);
            F_XOR_RR:   emit_rr(OpXor, q.rb, q.ra);
            F_SHL_CL:   emit_ext(OpShift, 3'd4, q.ra, 1'b1);
            F_SHR_CL:   emit_ext(OpShift, 3'd5, q.ra, 1'b1);
            F_NOT_R:    emit_ext(OpNotNeg, 3'd2, q.ra, 1'b1);
            F_NEG_R:    emit_ext(OpNotNeg, 3'd3, q.ra, 1'b1);
            F_CMP_RR:   emit_rr(OpCmp, q.rb, q.ra);
            F_TEST_RR:  emit_rr(OpTest, q.rb, q.ra);
            F_PUSH_R, F_POP_R: begin
                if (q.ra[3]) enc_bytes.push_back(RexB);
                enc_bytes.push_back((q.func == F_PUSH_R ? OpPush : OpPop)
                                    | {5'd0, q.ra[2:0]});
            end
            F_RET:      enc_bytes.push_back(OpRet);
            F_CALL_R:   emit_ext(OpGrp5, 3'd2, q.ra, 1'b0);
            F_JMP_REL: begin
                enc_bytes.push_back(OpJmp);
                emit32(q.disp);
            end
            F_JMP_R:    emit_ext(OpGrp5, 3'd4, q.ra, 1'b0);
            F_JCC_REL: begin
                enc_bytes.push_back(OpEsc);
                enc_bytes.push_back(q.cond);
                emit32(q.disp);
            end
            F_SETCC_R: begin
                if (q.ra[3]) enc_bytes.push_back(RexB);
                else if (q.ra >= 4'd4) enc_bytes.push_back(RexBare);
                enc_bytes.push_back(OpEsc);
                enc_bytes.push_back(q.cond);
                emit_modrm(2'd3, 4'd0, q.ra);
            end
            F_LOAD64, F_STORE64: begin
                emit_rex(1'b1, q.ra, 4'd0, q.base);
                enc_bytes.push_back(q.func == F_LOAD64 ? OpLoad : OpStore);
                emit_mem(q.ra, q.base, q.disp);
            end
            F_LOAD64_IDX:  emit_idx(OpLoad, q);
            F_STORE64_IDX: emit_idx(OpStore, q);
            F_MOVABS_R: begin
                emit_rex(1'b1, 4'd0, 4'd0, q.ra);
                enc_bytes.push_back(OpMovR | {5'd0, q.ra[2:0]});
                emit32(q.imm[31:0]);
                emit32(q.imm[63:32]);
            end
            F_STORE_IMM32: begin
                emit_rex(1'b0, 4'd0, 4'd0, q.base);
                enc_bytes.push_back(OpMovI);
                emit_mem(4'd0, q.base, q.disp);
                emit32(q.imm[31:0]);
            end
            default: ;
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req q;
        q.func = t_func'($urandom_range(29));
        if ($urandom_range(49) == 0) q.func = t_func'($urandom_range(31, 30));
        q.ra = 4'($urandom);
        q.rb = 4'($urandom);
        q.base = 4'($urandom);
        q.idx = 4'($urandom);
        q.sc = 2'($urandom);
        q.cond = 8'($urandom);
        case ($urandom_range(3))
            0: q.disp = 32'd0;
            1: q.disp = $urandom_range(255) - 128;
            default: q.disp = $urandom;
        endcase
        case ($urandom_range(4))
            0: q.imm = {32'd0, 1'b0, 31'($urandom)};
            1: q.imm = {32'hFFFFFFFF, 1'b1, 31'($urandom)};
            2: q.imm = 64'($signed(32'($urandom_range(300)) - 32'sd150));
            default: q.imm = {32'($urandom), 32'($urandom)};
        endcase
        return q;
    endfunction

    // Sends one request, waiting out backpressure and random gaps.
    task automatic send_req(input t_req q);
        while (idle_now()) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        encode_instr(q);
        foreach (enc_bytes[i])
            code_q.push_back({enc_bytes[i], i == enc_bytes.size() - 1});
        i_push       <= 1'b1;
        i_func       <= q.func;
        i_reg_a      <= q.ra;
        i_reg_b      <= q.rb;
        i_base_reg   <= q.base;
        i_index_reg  <= q.idx;
        i_scale_log2 <= q.sc;
        i_disp       <= q.disp;
        i_imm        <= q.imm;
        i_cond_byte  <= q.cond;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        op_hits[q.func]++;
        sent_count++;
    endtask

    function automatic t_req mk(t_func f, logic [3:0] ra, logic [3:0] rb, logic [3:0] base,
                                logic [3:0] idx, logic [31:0] d, logic [63:0] imm);
        t_req q;
        q.func = f; q.ra = ra; q.rb = rb; q.base = base; q.idx = idx;
        q.sc = 2'd3; q.disp = d; q.imm = imm; q.cond = 8'h94;
        return q;
    endfunction

    task automatic wait_drained();
        i_push <= 1'b0;
        while (code_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_each_operation();
        for (int f = 0; f < 32; f++)
            send_req(mk(t_func'(f), 4'd9, 4'd14, 4'd3, 4'd10, 32'h1234, 64'h12345678));
    endtask

    task automatic test_special_cases();
        send_req(mk(F_MOV_RR, 4'd7, 4'd7, '0, '0, '0, '0));
        send_req(mk(F_LOAD64, 4'd15, '0, 4'd4, '0, '0, '0));
        send_req(mk(F_STORE64, 4'd0, '0, 4'd12, '0, 32'h7F, '0));
        send_req(mk(F_LOAD64, 4'd1, '0, 4'd5, '0, '0, '0));
        send_req(mk(F_STORE_IMM32, '0, '0, 4'd13, '0, 32'hFFFFFF80, 64'hFFFFFFFF));
        send_req(mk(F_STORE64, 4'd8, '0, 4'd2, '0, 32'h80000000, '0));
        send_req(mk(F_LOAD64_IDX, 4'd2, '0, 4'd13, 4'd4, '0, '0));
        send_req(mk(F_STORE64_IDX, 4'd15, '0, 4'd15, 4'd15, '0, '0));
        send_req(mk(F_MOV_RI64, 4'd1, '0, '0, '0, '0, 64'h7FFFFFFF));
        send_req(mk(F_MOV_RI64, 4'd9, '0, '0, '0, '0, 64'hFFFFFFFF80000000));
        send_req(mk(F_MOV_RI64, 4'd2, '0, '0, '0, '0, 64'h0000000080000000));
        send_req(mk(F_ADD_RI, 4'd3, '0, '0, '0, '0, 64'hFFFFFF80));
        send_req(mk(F_ADD_RI, 4'd3, '0, '0, '0, '0, 64'h80));
        send_req(mk(F_SETCC_R, 4'd4, '0, '0, '0, '0, '0));
        send_req(mk(F_SETCC_R, 4'd3, '0, '0, '0, '0, '0));
        send_req(mk(F_MOVABS_R, 4'd15, '0, '0, '0, '0, 64'hFFFFFFFFFFFFFFFF));
        // Hold the sender until every byte has drained.
        wait_drained();
    endtask

    task automatic test_random_stream();
        for (int n = 0; n < 200; n++) begin
            quiet_stretch = (n >= 80 && n < 120);
            send_req(rand_req());
        end
        quiet_stretch = 1'b0;
    endtask

    // Consumes bytes and compares them against the predicted stream.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (code_q.size() == 0) begin
                report("unexpected byte", o_out_byte, 8'h00);
            end else begin
                if (o_out_byte !== code_q[0][8:1]) report("byte", o_out_byte, code_q[0][8:1]);
                if (o_last !== code_q[0][0]) report("last", {7'd0, o_last}, {7'd0, code_q[0][0]});
                void'(code_q.pop_front());
            end
            byte_count++;
        end
        i_pop <= i_rst_n && !idle_now();
    end

    initial begin
        i_rst_n = 1'b0; i_push = 1'b0; i_pop = 1'b0;
        i_func = '0; i_reg_a = '0; i_reg_b = '0; i_base_reg = '0; i_index_reg = '0;
        i_scale_log2 = '0; i_disp = '0; i_imm = '0; i_cond_byte = '0;
        quiet_stretch = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_each_operation();
        test_special_cases();
        test_random_stream();
        wait_drained();
        $display("sent %0d requests covering every operation code, checked %0d bytes",
                 sent_count, byte_count);
        if (error_count == 0) $display("tb_x86_64_instruction_encoder: clean");
        else $display("tb_x86_64_instruction_encoder: errors");
        $finish;
    end

    initial begin
        #200000;
        $display("tb_x86_64_instruction_encoder: errors");
        $finish;
    end

endmodule
